@@ hdl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int TAG_BITS  = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OCC_W     = 5;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                 valid;
		logic [PRIO_BITS-1:0] prio;
		logic [TAG_BITS-1:0]  tag;
	} entry_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} cmd_t;

endpackage
`default_nettype wire

@@ hdl/spq_cell.sv @@
`default_nettype none
module spq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spq_pkg::cmd_t cmd,
	input  wire spq_pkg::entry_t new_ent,
	input  wire spq_pkg::entry_t left_ent,
	input  wire logic          left_keep,
	input  wire spq_pkg::entry_t right_ent,
	output spq_pkg::entry_t    cur_ent,
	output logic               keep
);
	import spq_pkg::*;

	logic                 valid_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [TAG_BITS-1:0]  tag_q;
	entry_t               nxt;

	assign cur_ent = '{valid: valid_q, prio: prio_q, tag: tag_q};

	// A cell keeps its entry on a push when it outranks or ties the newcomer,
	// which keeps equal priorities in arrival order.
	assign keep = valid_q && (prio_q >= new_ent.prio);

	always_comb begin
		nxt = cur_ent;
		if (cmd.clr) begin
			nxt.valid = 1'b0;
		end else if (cmd.pop) begin
			nxt = right_ent;
		end else if (cmd.push && !keep) begin
			nxt = left_keep ? new_ent : left_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt.prio;
		tag_q  <= nxt.tag;
	end

endmodule
`default_nettype wire

@@ hdl/stable_priority_queue.sv @@
`default_nettype none
// Bounded priority queue of sixteen entries, kept sorted with the highest
// priority at the head; equal priorities leave in arrival order.
// Input channel: in_valid/in_stall carry one beat of op, prio and tag.
// Operation push inserts an entry, pop removes the head, clear empties all.
// Output channel: out_valid/out_stall carry one result beat per input beat:
// status, the head entry after the operation and the occupancy.
// The entries sit in a chain of cells; on a push every cell compares its
// priority with the new one in parallel and either holds, takes the new
// entry or takes its left neighbor; on a pop every cell takes its right
// neighbor. The result appears in the cycle after the input beat is taken,
// and one beat per cycle is sustained while out_stall is low.
// The result stays in the cells and the output register; while out_stall is
// high the result holds and in_stall is raised, so no further beat enters.
// Reset empties the queue and clears out_valid; entry payloads are not
// cleared, empty slots are marked by their valid bits.
// A push into a full queue is dropped with status full; pop or clear on an
// empty queue reports status empty.
module stable_priority_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [spq_pkg::PRIO_BITS-1:0] prio,
	input  wire logic [spq_pkg::TAG_BITS-1:0]  tag,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic                               head_valid,
	output logic [spq_pkg::PRIO_BITS-1:0]      head_prio,
	output logic [spq_pkg::TAG_BITS-1:0]       head_tag,
	output logic [spq_pkg::OCC_W-1:0]          occupancy
);
	import spq_pkg::*;

	logic             accept;
	logic             full;
	logic             empty;
	op_t              op_in;
	cmd_t             cmd;
	status_t          status_nxt;
	status_t          status_q;
	logic [CNT_W-1:0] fill_nxt;
	logic [CNT_W-1:0] fill_count_q;
	logic             out_valid_q;
	entry_t           new_ent;
	entry_t           ents [DEPTH];
	logic             keeps [DEPTH];
	logic [DEPTH-1:0] valid_vec;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign op_in    = op_t'(op);
	assign empty    = !ents[0].valid;
	assign full     = ents[DEPTH-1].valid;
	assign new_ent  = '{valid: 1'b1, prio: prio, tag: tag};

	always_comb begin
		cmd        = '0;
		status_nxt = ST_OK;
		fill_nxt   = fill_count_q;
		case (op_in)
			OP_PUSH: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.push = accept;
					fill_nxt = fill_count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.pop  = accept;
					fill_nxt = fill_count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.clr  = accept;
					fill_nxt = '0;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_keep;

		if (i == 0) begin : g_first
			assign left_ent  = new_ent;
			assign left_keep = 1'b1;
		end else begin : g_mid
			assign left_ent  = ents[i-1];
			assign left_keep = keeps[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_ent   (new_ent),
			.left_ent  (left_ent),
			.left_keep (left_keep),
			.right_ent (right_ent),
			.cur_ent   (ents[i]),
			.keep      (keeps[i])
		);

		assign valid_vec[i] = ents[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			fill_count_q <= '0;
			status_q     <= ST_OK;
		end else begin
			if (accept) begin
				out_valid_q  <= 1'b1;
				fill_count_q <= fill_nxt;
				status_q     <= status_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The cells already hold the state after the last beat, so the head is
	// read straight from the first cell.
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign head_valid = ents[0].valid;
	assign head_prio  = ents[0].valid ? ents[0].prio : '0;
	assign head_tag   = ents[0].valid ? ents[0].tag : '0;
	assign occupancy  = OCC_W'(fill_count_q);

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_count_q))
		else $error("fill count disagrees with valid cells");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid == (fill_count_q != '0))
		else $error("head valid disagrees with fill count");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_in == OP_PUSH && !full) |=>
		(fill_count_q == $past(fill_count_q) + CNT_W'(1)))
		else $error("accepted push did not add an entry");

	for (genvar j = 0; j < DEPTH - 1; j++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(ents[j+1].valid) |-> (ents[j].valid && ents[j].prio >= ents[j+1].prio))
			else $error("queue order broken");
	end
`endif

endmodule
`default_nettype wire

@@ verif/spq_checker.sv @@
// Watches both channels of the priority queue, keeps its own sorted copy of the
// entries, and compares each result beat with the oldest predicted result.
module spq_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [spq_pkg::PRIO_BITS-1:0] prio,
	input  wire logic [spq_pkg::TAG_BITS-1:0]  tag,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [1:0]                    status,
	input  wire logic                          head_valid,
	input  wire logic [spq_pkg::PRIO_BITS-1:0] head_prio,
	input  wire logic [spq_pkg::TAG_BITS-1:0]  head_tag,
	input  wire logic [spq_pkg::OCC_W-1:0]     occupancy,
	output int                                 mismatches,
	output int                                 awaiting,
	output int                                 results_seen,
	output int                                 full_drops,
	output int                                 empty_ops
);
	import spq_pkg::*;

	typedef struct {
		logic [1:0]           status;
		logic                 head_valid;
		logic [PRIO_BITS-1:0] head_prio;
		logic [TAG_BITS-1:0]  head_tag;
		logic [OCC_W-1:0]     occupancy;
	} queue_result_t;

	logic [PRIO_BITS-1:0] sorted_prio [DEPTH];
	logic [TAG_BITS-1:0]  sorted_tag [DEPTH];
	int unsigned          held = 0;
	queue_result_t        predicted_results [$];

	initial begin
		mismatches   = 0;
		awaiting     = 0;
		results_seen = 0;
		full_drops   = 0;
		empty_ops    = 0;
	end

	// Applies one operation to the shadow queue and returns the result it causes.
	function automatic queue_result_t apply_queue_op(logic [1:0] o, logic [PRIO_BITS-1:0] p,
			logic [TAG_BITS-1:0] t);
		queue_result_t r;
		int unsigned   pos;
		r.status = ST_OK;
		case (o)
			OP_PUSH: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// A new entry goes behind every entry of equal or higher priority.
					pos = 0;
					while (pos < held && sorted_prio[pos] >= p)
						pos++;
					for (int unsigned i = held; i > pos; i--) begin
						sorted_prio[i] = sorted_prio[i-1];
						sorted_tag[i]  = sorted_tag[i-1];
					end
					sorted_prio[pos] = p;
					sorted_tag[pos]  = t;
					held++;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int unsigned i = 0; i + 1 < held; i++) begin
						sorted_prio[i] = sorted_prio[i+1];
						sorted_tag[i]  = sorted_tag[i+1];
					end
					held--;
				end
			end
			OP_CLEAR: begin
				if (held == 0)
					r.status = ST_EMPTY;
				else
					held = 0;
			end
			default: begin
			end
		endcase
		r.head_valid = (held > 0);
		r.head_prio  = (held > 0) ? sorted_prio[0] : '0;
		r.head_tag   = (held > 0) ? sorted_tag[0] : '0;
		r.occupancy  = OCC_W'(held);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			// The result of an earlier beat is compared before this edge's input beat
			// is predicted, so the queue order matches the order of the results.
			if (out_valid && !out_stall) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					$error("result beat with nothing pending: status %0d occupancy %0d",
						status, occupancy);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
					check_field("head_prio", 32'(want.head_prio), 32'(head_prio));
					check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
					check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_queue_op(op, prio, tag);
				if (want.status == ST_FULL)
					full_drops++;
				if (want.status == ST_EMPTY)
					empty_ops++;
				predicted_results.push_back(want);
			end
			awaiting = predicted_results.size();
		end
	end

endmodule

@@ verif/stable_priority_queue_test.sv @@
module stable_priority_queue_test;
	import spq_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         RANDOM_BEATS = 1600;
	localparam int         PHASE_BEATS  = 200;
	localparam int         HOLD_CYCLES  = 80;
	localparam int         CYCLE_LIMIT  = 600000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           op;
	logic [PRIO_BITS-1:0] prio;
	logic [TAG_BITS-1:0]  tag;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic                 head_valid;
	logic [PRIO_BITS-1:0] head_prio;
	logic [TAG_BITS-1:0]  head_tag;
	logic [OCC_W-1:0]     occupancy;

	int mismatches;
	int awaiting;
	int results_seen;
	int full_drops;
	int empty_ops;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;

	stable_priority_queue DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.prio       (prio),
		.tag        (tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_valid (head_valid),
		.head_prio  (head_prio),
		.head_tag   (head_tag),
		.occupancy  (occupancy)
	);

	spq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.prio         (prio),
		.tag          (tag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.head_valid   (head_valid),
		.head_prio    (head_prio),
		.head_tag     (head_tag),
		.occupancy    (occupancy),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.results_seen (results_seen),
		.full_drops   (full_drops),
		.empty_ops    (empty_ops)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stable_priority_queue_test failed");
			$finish;
		end
	end

	// Mostly no gap, some short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic [1:0] o, input logic [PRIO_BITS-1:0] p,
			input logic [TAG_BITS-1:0] t);
		int gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		prio     <= p;
		tag      <= t;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = gap_len();
				if (stall_left > 0) begin
					out_stall <= 1'b1;
					stall_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		int                   mode;
		int                   r;
		logic [1:0]           o;
		logic [PRIO_BITS-1:0] p;
		in_valid = 1'b0;
		op       = OP_PUSH;
		prio     = '0;
		tag      = '0;
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty-queue cases first: pop and clear report empty, the unused code reports ok.
		send_beat(OP_POP, 8'hff, 16'hffff);
		send_beat(OP_CLEAR, 8'h00, 16'h0000);
		send_beat(OP_UNUSED, 8'h5a, 16'ha5a5);
		// Fill to the limit with extremes and repeated priorities to exercise ties.
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0: p = 8'hff;
				1: p = 8'h00;
				2: p = 8'h80;
				default: p = 8'h80;
			endcase
			send_beat(OP_PUSH, p, (i == 0) ? 16'hffff : TAG_BITS'(i * 16'h1111));
		end
		send_beat(OP_PUSH, 8'hff, 16'hbeef);
		send_beat(OP_UNUSED, 8'h00, 16'h0000);
		send_beat(OP_POP, 8'h00, 16'h0000);
		send_beat(OP_CLEAR, 8'hff, 16'hffff);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % PHASE_BEATS == 0) begin
				quiet = ((n / PHASE_BEATS) == 3) || ((n / PHASE_BEATS) == 6);
				// Stop taking results for a while so the block backs up its input.
				if ((n / PHASE_BEATS) == 3)
					hold_request = 1'b1;
			end
			mode = (n / PHASE_BEATS) % 3;
			r = $urandom_range(0, 99);
			case (mode)
				0: o = (r < 70) ? OP_PUSH : (r < 95) ? OP_POP : (r < 98) ? OP_CLEAR : OP_UNUSED;
				1: o = (r < 35) ? OP_PUSH : (r < 95) ? OP_POP : (r < 98) ? OP_CLEAR : OP_UNUSED;
				default: o = (r < 50) ? OP_PUSH : (r < 95) ? OP_POP : (r < 98) ? OP_CLEAR
					: OP_UNUSED;
			endcase
			r = $urandom_range(0, 99);
			if (r < 40)
				p = PRIO_BITS'($urandom_range(0, 3));
			else if (r < 45)
				p = 8'hff;
			else
				p = PRIO_BITS'($urandom);
			send_beat(o, p, TAG_BITS'($urandom));
		end
		in_valid <= 1'b0;

		while (awaiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d result beats over directed and random push, pop and clear traffic.",
			results_seen);
		$display("Saw %0d pushes dropped on a full queue and %0d pops or clears on an empty one.",
			full_drops, empty_ops);
		if (mismatches == 0)
			$display("stable_priority_queue_test passed");
		else
			$display("stable_priority_queue_test failed");
		$finish;
	end

endmodule
